>>> sv/sol_pkg.sv
// Shared types, codes and constants of the sprite outline highlight block.
// No dependencies; every other file of the block but sol_ram imports this package.
package sol_pkg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0] COMP_MAX   = 8'd255;
    localparam logic [9:0] MEAN_SCALE = 10'd765;

    typedef logic [2:0] t_step;
    localparam t_step STEP_CENTER = 3'd0;
    localparam t_step STEP_UP     = 3'd1;
    localparam t_step STEP_DOWN   = 3'd2;
    localparam t_step STEP_LEFT   = 3'd3;
    localparam t_step STEP_RIGHT  = 3'd4;
    localparam t_step STEP_END    = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_SCAN,
        ST_RESULT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       kind;
        logic [3:0] x;
        logic [3:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       transparent;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       visible;
    } t_hl_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       trans;
    } t_pix_word;

    localparam t_pix_word CLEAR_WORD = '{red: 8'd0, green: 8'd0, blue: 8'd0, trans: 1'b1};

    typedef struct packed {
        logic capture;
        logic clr;
        logic scan;
        logic ld_wr;
        logic result;
    } t_cmd;

    typedef struct packed {
        logic in_inside;
        logic in_is_load;
        logic clr_done;
        logic scan_done;
    } t_status;

    function automatic logic [9:0] comp_total(input t_pix_word w);
        return 10'(w.red) + 10'(w.green) + 10'(w.blue);
    endfunction

endpackage

>>> sv/sol_pix_if.sv
// Input channel of the sprite block: valid, ready and one pixel item.
// Depends on sol_pkg for the payload type.
interface sol_pix_if import sol_pkg::*; ();
    logic    valid;
    logic    ready;
    t_pix_in payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> sv/sol_hl_if.sv
// Result channel of the sprite block: valid, ready and one highlight pixel.
// Depends on sol_pkg for the payload type.
interface sol_hl_if import sol_pkg::*; ();
    logic    valid;
    logic    ready;
    t_hl_out payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> sv/sol_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sol_ctrl.sv
// Controller state machine of the sprite block: clearing pass, loads, scans, results.
// Depends on sol_pkg; talks to the datapath only through t_cmd and t_status.
module sol_ctrl import sol_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_st,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_st.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (!i_st.in_inside) begin
                        n_state = i_st.in_is_load ? ST_IDLE : ST_RESULT;
                    end else begin
                        n_state = i_st.in_is_load ? ST_LD_RD : ST_SCAN;
                    end
                end
            end
            ST_LD_RD: begin
                n_state = ST_LD_WR;
            end
            ST_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_st.scan_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                o_cmd.result = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> sv/sol_datapath.sv
// Datapath of the sprite block: pixel RAM, neighbor scan, opaque sum and count.
// Depends on sol_pkg and sol_ram; commanded by sol_ctrl.
module sol_datapath import sol_pkg::*; #(
    parameter int SPRITE_SIDE = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_pix_in i_pix,
    output t_status o_st,
    output t_hl_out o_hl
);

    localparam int NPIX  = SPRITE_SIDE * SPRITE_SIDE;
    localparam int AW    = $clog2(NPIX);
    localparam int SUM_W = $clog2(NPIX * int'(MEAN_SCALE) + 1);
    localparam int CNT_W = $clog2(NPIX + 1);
    localparam int CMP_W = SUM_W + 1;

    logic [3:0]       r_x;
    logic [3:0]       r_y;
    logic             r_kind;
    logic             r_inside;
    t_pix_word        r_new;
    t_step            r_step;
    logic             r_aok;
    t_pix_word        r_cen;
    logic             r_nb_any;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [AW-1:0]    r_clr_addr;
    t_hl_out          r_out;

    logic [4:0]       w_ax;
    logic [4:0]       w_ay;
    logic             w_aok;
    logic [AW-1:0]    w_raddr;
    logic [AW-1:0]    w_caddr;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_pix_word        w_wdata;
    t_pix_word        w_rdata;
    logic             w_in_inside;
    logic             w_edge;
    logic             w_dark;
    logic [7:0]       w_opp;
    logic [7:0]       w_same;
    logic [SUM_W-1:0] w_old_tot;
    logic [SUM_W-1:0] w_new_tot;

    assign w_in_inside = (32'(i_pix.x) < SPRITE_SIDE) && (32'(i_pix.y) < SPRITE_SIDE);

    always_comb begin
        w_ax  = {1'b0, r_x};
        w_ay  = {1'b0, r_y};
        w_aok = 1'b1;
        case (r_step)
            STEP_UP: begin
                w_ay  = {1'b0, r_y} - 5'd1;
                w_aok = (r_y != 4'd0);
            end
            STEP_DOWN: begin
                w_ay  = {1'b0, r_y} + 5'd1;
                w_aok = (32'(w_ay) < SPRITE_SIDE);
            end
            STEP_LEFT: begin
                w_ax  = {1'b0, r_x} - 5'd1;
                w_aok = (r_x != 4'd0);
            end
            STEP_RIGHT: begin
                w_ax  = {1'b0, r_x} + 5'd1;
                w_aok = (32'(w_ax) < SPRITE_SIDE);
            end
            default: begin
                w_aok = 1'b1;
            end
        endcase
    end

    assign w_caddr = AW'(32'(r_y) * SPRITE_SIDE + 32'(r_x));
    assign w_raddr = w_aok ? AW'(32'(w_ay) * SPRITE_SIDE + 32'(w_ax)) : '0;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_caddr;
        w_wdata = r_new;
        if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = CLEAR_WORD;
        end else if (i_cmd.ld_wr) begin
            w_we = 1'b1;
        end
    end

    sol_ram #(
        .WIDTH ($bits(t_pix_word)),
        .DEPTH (NPIX)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_old_tot = w_rdata.trans ? '0 : SUM_W'(comp_total(w_rdata));
    assign w_new_tot = r_new.trans ? '0 : SUM_W'(comp_total(r_new));

    assign w_dark = (r_count != '0)
        && (CMP_W'({r_sum, 1'b0}) < CMP_W'(r_count) * CMP_W'(MEAN_SCALE));
    assign w_opp  = w_dark ? COMP_MAX : 8'd0;
    assign w_same = COMP_MAX - w_opp;
    assign w_edge = (r_x == 4'd0) || (r_y == 4'd0)
        || (32'(r_x) == SPRITE_SIDE - 1) || (32'(r_y) == SPRITE_SIDE - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_count    <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.ld_wr) begin
                r_sum   <= r_sum - w_old_tot + w_new_tot;
                r_count <= r_count - CNT_W'(!w_rdata.trans) + CNT_W'(!r_new.trans);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x      <= i_pix.x;
            r_y      <= i_pix.y;
            r_kind   <= i_pix.kind;
            r_inside <= w_in_inside;
            r_new    <= '{red: i_pix.red, green: i_pix.green, blue: i_pix.blue,
                          trans: i_pix.transparent};
            r_step   <= STEP_CENTER;
            r_nb_any <= 1'b0;
        end else if (i_cmd.scan) begin
            r_step <= r_step + t_step'(1);
            r_aok  <= w_aok;
            if (r_step == STEP_UP) begin
                r_cen <= w_rdata;
            end else if (r_step != STEP_CENTER && r_aok && !w_rdata.trans) begin
                r_nb_any <= 1'b1;
            end
        end
        if (i_cmd.result) begin
            if (!r_inside || r_kind == KIND_LOAD) begin
                r_out <= '0;
            end else if (r_cen.trans && r_nb_any) begin
                r_out <= '{out_red: w_same, out_green: w_same, out_blue: w_same,
                           visible: 1'b1};
            end else if (!r_cen.trans && w_edge) begin
                r_out <= '{out_red: w_opp, out_green: w_opp, out_blue: w_opp,
                           visible: 1'b1};
            end else begin
                r_out <= '{out_red: r_cen.red, out_green: r_cen.green,
                           out_blue: r_cen.blue, visible: 1'b0};
            end
        end
    end

    assign o_st.in_inside  = w_in_inside;
    assign o_st.in_is_load = (i_pix.kind == KIND_LOAD);
    assign o_st.clr_done   = (r_clr_addr == AW'(NPIX - 1));
    assign o_st.scan_done  = (r_step == STEP_END);
    assign o_hl            = r_out;

endmodule

>>> sv/sprite_outline_highlight.sv
// Top level of the sprite outline highlight block: controller plus datapath.
// Depends on sol_pkg, sol_pix_if, sol_hl_if, sol_ctrl and sol_datapath.
//
//  Port   | Direction | Transfer carries
//  -------+-----------+---------------------------------------------------
//  i_pix  | in        | kind, x, y, red, green, blue, transparent
//  o_hl   | out       | out_red, out_green, out_blue, visible (reads only)
//
// A load inside the sprite is a read-modify-write of the pixel RAM.
// A read inside the sprite scans the pixel and its four neighbors through the one
// RAM read port before its result; a read outside the sprite skips the scan.
// After reset a clearing pass writes all SPRITE_SIDE*SPRITE_SIDE RAM entries,
// one per cycle, before the first transfer is taken.
// A result waits in its output register until taken; no new item enters meanwhile.
module sprite_outline_highlight import sol_pkg::*; #(
    parameter int SPRITE_SIDE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sol_pix_if.sink    i_pix,
    sol_hl_if.source   o_hl
);

    t_cmd    w_cmd;
    t_status w_st;

    sol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_out_ready (o_hl.ready),
        .i_st        (w_st),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_hl.valid),
        .o_cmd       (w_cmd)
    );

    sol_datapath #(
        .SPRITE_SIDE (SPRITE_SIDE)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_pix   (i_pix.payload),
        .o_st    (w_st),
        .o_hl    (o_hl.payload)
    );

endmodule
